/* rtl/isbc_pkg.sv */
// shared types and constants of the imu static bias calibrator
package isbc_pkg;

	localparam int NUM_AXES = 3;
	localparam int NUM_CH   = 6;

	localparam logic [20:0] GRAVITY_RESET = 21'd642908;
	localparam logic [15:0] TARGET_RESET  = 16'd20;
	localparam logic [16:0] COUNT_MAX     = 17'h1FFFF;

	localparam logic [1:0] CFG_GRAVITY = 2'd0;
	localparam logic [1:0] CFG_TARGET  = 2'd1;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef enum logic [3:0] {
		L_IDLE, L_DIVM, L_ERR, L_SQ, L_MULLO, L_MULHI, L_DIV1, L_DIV2, L_SUM
	} lane_state_t;

	typedef enum logic [3:0] {
		M_IDLE, M_SQ, M_SQRT, M_NN, M_SLO, M_SHI, M_SCHK, M_SDIV, M_GMUL, M_GDIV
	} merge_state_t;

	typedef enum logic [2:0] {
		T_IDLE, T_UPD, T_LANES, T_MGO, T_MERGE
	} top_state_t;

	typedef struct packed {
		logic start;
		logic scale;
	} merge_ctrl_t;

endpackage

/* rtl/isbc_lane.sv */
// one channel of the running mean and variance update, with its own serial divider
module isbc_lane
	import isbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] x,
	input  logic [31:0] mean_in,
	input  logic [31:0] var_in,
	input  logic [16:0] n,
	output logic        busy,
	output logic [31:0] mean_out,
	output logic [31:0] var_out
);

	lane_state_t state_q, state_d;

	logic [31:0] x_q, mean_q, var_q, a_q, t1_q;
	logic [16:0] n_q, nm1_q;
	logic        neg_q, t2sat_q;
	logic [33:0] rem_q, div_q, n2_q;
	logic [32:0] dvd_q;
	logic [5:0]  cnt_q;
	logic [63:0] sq_q;
	logic [48:0] vn_q, plo_q;
	logic [80:0] p_q;

	logic [34:0] r2, rnext;
	logic        ge;
	logic [32:0] d_full, d_mag, e_full, e_mag, v_sum;
	logic [33:0] mean_sum;
	logic [48:0] phi;
	logic        sat;

	always_comb begin
		r2       = {rem_q, dvd_q[32]};
		ge       = r2 >= {1'b0, div_q};
		rnext    = ge ? r2 - {1'b0, div_q} : r2;
		d_full   = {x[31], x} - {mean_in[31], mean_in};
		d_mag    = d_full[32] ? -d_full : d_full;
		mean_sum = {{2{mean_q[31]}}, mean_q} + (neg_q ? -{1'b0, dvd_q} : {1'b0, dvd_q});
		e_full   = {x_q[31], x_q} - {mean_q[31], mean_q};
		e_mag    = e_full[32] ? -e_full : e_full;
		phi      = sq_q[63:32] * nm1_q;
		sat      = {1'b0, p_q[80:48]} >= n2_q;
		v_sum    = {1'b0, t1_q} + {1'b0, dvd_q[31:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			L_IDLE:  if (start) state_d = L_DIVM;
			L_DIVM:  if (cnt_q == 6'd0) state_d = L_ERR;
			L_ERR:   state_d = L_SQ;
			L_SQ:    state_d = L_MULLO;
			L_MULLO: state_d = L_MULHI;
			L_MULHI: state_d = L_DIV1;
			L_DIV1:  if (cnt_q == 6'd0) state_d = sat ? L_SUM : L_DIV2;
			L_DIV2:  if (cnt_q == 6'd0) state_d = L_SUM;
			L_SUM:   state_d = L_IDLE;
			default: state_d = L_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				if (start) begin
					x_q    <= x;
					mean_q <= mean_in;
					var_q  <= var_in;
					n_q    <= n;
					nm1_q  <= n - 17'd1;
					neg_q  <= d_full[32];
					rem_q  <= '0;
					dvd_q  <= d_mag;
					div_q  <= {17'b0, n};
					cnt_q  <= 6'd33;
				end
			end
			L_DIVM: begin
				if (cnt_q != 6'd0) begin
					rem_q <= rnext[33:0];
					dvd_q <= {dvd_q[31:0], ge};
					cnt_q <= cnt_q - 6'd1;
				end else begin
					mean_q <= mean_sum[31:0];
				end
			end
			L_ERR: a_q <= e_mag[31:0];
			L_SQ: begin
				sq_q <= a_q * a_q;
				vn_q <= var_q * nm1_q;
				n2_q <= n_q * n_q;
			end
			L_MULLO: plo_q <= sq_q[31:0] * nm1_q;
			L_MULHI: begin
				p_q   <= {phi, 32'b0} + {32'b0, plo_q};
				rem_q <= {17'b0, vn_q[48:32]};
				dvd_q <= {vn_q[31:0], 1'b0};
				div_q <= {17'b0, n_q};
				cnt_q <= 6'd32;
			end
			L_DIV1: begin
				if (cnt_q != 6'd0) begin
					rem_q <= rnext[33:0];
					dvd_q <= {dvd_q[31:0], ge};
					cnt_q <= cnt_q - 6'd1;
				end else begin
					// second term saturates when the top half already reaches n*n
					t1_q    <= dvd_q[31:0];
					t2sat_q <= sat;
					rem_q   <= {1'b0, p_q[80:48]};
					dvd_q   <= {p_q[47:16], 1'b0};
					div_q   <= n2_q;
					cnt_q   <= 6'd32;
				end
			end
			L_DIV2: begin
				if (cnt_q != 6'd0) begin
					rem_q <= rnext[33:0];
					dvd_q <= {dvd_q[31:0], ge};
					cnt_q <= cnt_q - 6'd1;
				end
			end
			L_SUM: var_q <= (t2sat_q || v_sum[32]) ? '1 : v_sum[31:0];
			default: ;
		endcase
	end

	assign busy     = state_q != L_IDLE;
	assign mean_out = mean_q;
	assign var_out  = var_q;

endmodule

/* rtl/isbc_merge.sv */
// merges the acceleration means: norm, end-of-calibration rescale and gravity vector
module isbc_merge
	import isbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  merge_ctrl_t ctrl,
	input  logic [31:0] mean_in [NUM_AXES],
	input  logic [31:0] var_in [NUM_AXES],
	input  logic [20:0] g,
	output logic        busy,
	output logic [31:0] gc [NUM_AXES],
	output logic [31:0] var_out [NUM_AXES]
);

	merge_state_t state_q, state_d;

	logic [31:0] mag_q [NUM_AXES];
	logic        neg_q [NUM_AXES];
	logic [31:0] var_q [NUM_AXES];
	logic [31:0] gc_q [NUM_AXES];
	logic [20:0] g_q;
	logic        scale_q;
	logic [1:0]  k_q;
	logic [63:0] sq_q, sum_q, sqn_q, nn_q, rem_q, div_q;
	logic [31:0] root_q, dvd_q;
	logic [33:0] srem_q;
	logic [5:0]  cnt_q;
	logic [41:0] g2_q;
	logic [52:0] plo_q;
	logic [73:0] prod_q;

	logic [64:0] r2, rnext;
	logic        ge;
	logic [35:0] t, trial, tdiff;
	logic        sge;
	logic        ssat;
	logic        last_axis;
	logic [52:0] gp;
	logic [52:0] phi;

	always_comb begin
		r2        = {rem_q, dvd_q[31]};
		ge        = r2 >= {1'b0, div_q};
		rnext     = ge ? r2 - {1'b0, div_q} : r2;
		t         = {srem_q, sqn_q[63:62]};
		trial     = {2'b0, root_q, 2'b01};
		sge       = t >= trial;
		tdiff     = t - trial;
		ssat      = {22'b0, prod_q[73:32]} >= nn_q;
		last_axis = k_q == AXIS_Z;
		gp        = mag_q[k_q] * g_q;
		phi       = var_q[k_q] * g2_q[41:21];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			M_IDLE: if (ctrl.start) state_d = M_SQ;
			M_SQ:   if (k_q == 2'd3) state_d = M_SQRT;
			M_SQRT: begin
				if (cnt_q == 6'd0) begin
					if (root_q == '0) state_d = M_IDLE;
					else if (scale_q) state_d = M_NN;
					else state_d = M_GMUL;
				end
			end
			M_NN:   state_d = M_SLO;
			M_SLO:  state_d = M_SHI;
			M_SHI:  state_d = M_SCHK;
			M_SCHK: begin
				if (ssat) state_d = last_axis ? M_GMUL : M_SLO;
				else state_d = M_SDIV;
			end
			M_SDIV: if (cnt_q == 6'd0) state_d = last_axis ? M_GMUL : M_SLO;
			M_GMUL: state_d = M_GDIV;
			M_GDIV: if (cnt_q == 6'd0) state_d = last_axis ? M_IDLE : M_GMUL;
			default: state_d = M_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				if (ctrl.start) begin
					for (int i = 0; i < NUM_AXES; i++) begin
						neg_q[i] <= mean_in[i][31];
						mag_q[i] <= mean_in[i][31] ? -mean_in[i] : mean_in[i];
						var_q[i] <= var_in[i];
					end
					g_q     <= g;
					scale_q <= ctrl.scale;
					sq_q    <= '0;
					sum_q   <= '0;
					k_q     <= 2'd0;
				end
			end
			M_SQ: begin
				// squares are registered the cycle before they are accumulated
				sum_q <= sum_q + sq_q;
				sq_q  <= (k_q == 2'd3) ? '0 : mag_q[k_q] * mag_q[k_q];
				k_q   <= k_q + 2'd1;
				if (k_q == 2'd3) begin
					sqn_q  <= sum_q + sq_q;
					srem_q <= '0;
					root_q <= '0;
					cnt_q  <= 6'd32;
				end
			end
			M_SQRT: begin
				if (cnt_q != 6'd0) begin
					srem_q <= sge ? tdiff[33:0] : t[33:0];
					root_q <= {root_q[30:0], sge};
					sqn_q  <= {sqn_q[61:0], 2'b0};
					cnt_q  <= cnt_q - 6'd1;
				end else if (root_q == '0) begin
					for (int i = 0; i < NUM_AXES; i++) gc_q[i] <= '0;
				end
			end
			M_NN: begin
				nn_q <= root_q * root_q;
				g2_q <= g_q * g_q;
			end
			M_SLO: plo_q <= var_q[k_q] * g2_q[20:0];
			M_SHI: prod_q <= {phi, 21'b0} + {21'b0, plo_q};
			M_SCHK: begin
				if (ssat) begin
					var_q[k_q] <= '1;
					k_q        <= last_axis ? 2'd0 : k_q + 2'd1;
				end else begin
					rem_q <= {22'b0, prod_q[73:32]};
					dvd_q <= prod_q[31:0];
					div_q <= nn_q;
					cnt_q <= 6'd32;
				end
			end
			M_SDIV: begin
				if (cnt_q != 6'd0) begin
					rem_q <= rnext[63:0];
					dvd_q <= {dvd_q[30:0], ge};
					cnt_q <= cnt_q - 6'd1;
				end else begin
					var_q[k_q] <= dvd_q;
					k_q        <= last_axis ? 2'd0 : k_q + 2'd1;
				end
			end
			M_GMUL: begin
				rem_q <= {32'b0, gp[52:21]};
				dvd_q <= {gp[20:0], 11'b0};
				div_q <= {32'b0, root_q};
				cnt_q <= 6'd21;
			end
			M_GDIV: begin
				if (cnt_q != 6'd0) begin
					rem_q <= rnext[63:0];
					dvd_q <= {dvd_q[30:0], ge};
					cnt_q <= cnt_q - 6'd1;
				end else begin
					// component points against the mean acceleration
					gc_q[k_q] <= neg_q[k_q] ? {11'b0, dvd_q[20:0]} : -{11'b0, dvd_q[20:0]};
					k_q       <= k_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	assign busy    = state_q != M_IDLE;
	assign gc      = gc_q;
	assign var_out = var_q;

endmodule

/* rtl/imu_static_bias_calibrator_unit.sv */
// top level of the imu static bias calibrator: statistics, lanes, merge and output bank
// one sample at a time; lanes first, then merge: six lanes run a 33-step mean division
// and two 32-step variance divisions (the second skipped on saturation), then the merge
// unit runs a 32-step square root and, unless the norm is zero, three 21-step gravity
// divisions; the completing sample adds variance rescaling; later samples skip the lanes
// three result transfers per sample; the next sample is taken while results drain
// reset clears the statistics, sets the count to one and loads the register defaults
module imu_static_bias_calibrator_unit
	import isbc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [20:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [191:0] s_axis_tdata,  // acc_x, acc_y, acc_z, gyr_x, gyr_y, gyr_z
	input  logic         s_axis_tlast,  // frame_end
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // gravity_comp, gyro_bias, acc_variance, gyro_variance
	output logic [2:0]   m_axis_tuser,  // axis, init_done
	output logic         m_axis_tlast   // last
);

	top_state_t state_q, state_d;

	logic [20:0] g_q;
	logic [15:0] target_q;
	logic [16:0] count_q;
	logic [31:0] ch_mean_q [NUM_CH];
	logic [31:0] ch_var_q [NUM_CH];
	logic [31:0] in_q [NUM_CH];
	logic        seen_q, done_q, fe_q, end_q;

	logic [31:0] ob_gc_q [NUM_AXES];
	logic [31:0] ob_gb_q [NUM_AXES];
	logic [31:0] ob_av_q [NUM_AXES];
	logic [31:0] ob_gv_q [NUM_AXES];
	logic        ob_done_q, ob_valid_q;
	logic [1:0]  ob_idx_q;

	logic        in_fire, m_fire, lane_start, ob_load, end_c;
	logic [NUM_CH-1:0] lane_busy;
	logic [31:0] lane_mean [NUM_CH];
	logic [31:0] lane_var [NUM_CH];
	merge_ctrl_t mctrl;
	logic        merge_busy;
	logic [31:0] m_mean [NUM_AXES];
	logic [31:0] m_vin [NUM_AXES];
	logic [31:0] m_gc [NUM_AXES];
	logic [31:0] m_var [NUM_AXES];

	for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
		isbc_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (lane_start),
			.x        (in_q[i]),
			.mean_in  (ch_mean_q[i]),
			.var_in   (ch_var_q[i]),
			.n        (count_q),
			.busy     (lane_busy[i]),
			.mean_out (lane_mean[i]),
			.var_out  (lane_var[i])
		);
	end

	for (genvar i = 0; i < NUM_AXES; i++) begin : g_mrg
		assign m_mean[i] = ch_mean_q[i];
		assign m_vin[i]  = ch_var_q[i];
	end

	isbc_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mctrl),
		.mean_in (m_mean),
		.var_in  (m_vin),
		.g       (g_q),
		.busy    (merge_busy),
		.gc      (m_gc),
		.var_out (m_var)
	);

	assign cfg_ready = 1'b1;
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign m_fire    = m_axis_tvalid && m_axis_tready;
	assign end_c     = !done_q && fe_q && (count_q > {1'b0, target_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		lane_start    = 1'b0;
		mctrl         = '0;
		ob_load       = 1'b0;
		case (state_q)
			T_IDLE: begin
				s_axis_tready = 1'b1;
				if (in_fire) state_d = T_UPD;
			end
			T_UPD: begin
				lane_start = !done_q && seen_q;
				state_d    = (!done_q && seen_q) ? T_LANES : T_MGO;
			end
			T_LANES: if (lane_busy == '0) state_d = T_MGO;
			T_MGO: begin
				mctrl.start = 1'b1;
				mctrl.scale = end_c;
				state_d     = T_MERGE;
			end
			T_MERGE: begin
				// wait for the merge unit and for the bank to drain the previous sample
				if (!merge_busy && !ob_valid_q) begin
					ob_load = 1'b1;
					state_d = T_IDLE;
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q        <= GRAVITY_RESET;
			target_q   <= TARGET_RESET;
			count_q    <= 17'd1;
			seen_q     <= 1'b0;
			done_q     <= 1'b0;
			ob_valid_q <= 1'b0;
			ob_idx_q   <= AXIS_X;
			for (int i = 0; i < NUM_CH; i++) begin
				ch_mean_q[i] <= '0;
				ch_var_q[i]  <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GRAVITY: g_q <= cfg_data;
					CFG_TARGET:  target_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (state_q == T_UPD && !done_q && !seen_q) begin
				for (int i = 0; i < NUM_CH; i++) begin
					ch_mean_q[i] <= in_q[i];
					ch_var_q[i]  <= '0;
				end
				count_q <= 17'd2;
				seen_q  <= 1'b1;
			end
			if (state_q == T_LANES && lane_busy == '0) begin
				for (int i = 0; i < NUM_CH; i++) begin
					ch_mean_q[i] <= lane_mean[i];
					ch_var_q[i]  <= lane_var[i];
				end
				if (count_q != COUNT_MAX) count_q <= count_q + 17'd1;
			end
			if (ob_load) begin
				for (int i = 0; i < NUM_AXES; i++) ch_var_q[i] <= m_var[i];
				done_q     <= done_q || end_q;
				ob_valid_q <= 1'b1;
				ob_idx_q   <= AXIS_X;
			end else if (m_fire) begin
				if (ob_idx_q == AXIS_Z) ob_valid_q <= 1'b0;
				else ob_idx_q <= ob_idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < NUM_CH; i++) in_q[i] <= s_axis_tdata[32*i +: 32];
			fe_q <= s_axis_tlast;
		end
		if (state_q == T_MGO) end_q <= end_c;
		if (ob_load) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				ob_gc_q[i] <= m_gc[i];
				ob_gb_q[i] <= ch_mean_q[NUM_AXES + i];
				ob_av_q[i] <= m_var[i];
				ob_gv_q[i] <= ch_var_q[NUM_AXES + i];
			end
			ob_done_q <= done_q || end_q;
		end
	end

	assign m_axis_tvalid = ob_valid_q;
	assign m_axis_tdata  = {ob_gv_q[ob_idx_q], ob_av_q[ob_idx_q], ob_gb_q[ob_idx_q],
		ob_gc_q[ob_idx_q]};
	assign m_axis_tuser  = {ob_done_q, ob_idx_q};
	assign m_axis_tlast  = ob_idx_q == AXIS_Z;

endmodule

/* rtl/isbc_checker.sv */
// port-level checks of the calibrator and their binding to the top level
module isbc_checker
	import isbc_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata,
	input logic [2:0]   m_axis_tuser,
	input logic         m_axis_tlast
);

	a_last_axis: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[1:0] == AXIS_Z)))
		else $error("tlast does not mark the z axis");

	a_axis_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
		(m_axis_tvalid && m_axis_tuser[1:0] == $past(m_axis_tuser[1:0]) + 2'd1))
		else $error("result axes not in order");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tuser[2]) |=>
		(!m_axis_tvalid || m_axis_tuser[2]))
		else $error("init_done dropped after calibration");

	a_one_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken while a sample is in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result transfer changed");

endmodule

bind imu_static_bias_calibrator_unit isbc_checker u_isbc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
